// ===== hdl/srg_pkg.sv =====
// Shared types and constants for the segment ramp rpm generator.
package srg_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam logic [15:0] MAX_RPM_RESET = 16'd10000;

  // result status codes
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_START  = 3'd2,
    OP_TICK   = 3'd3,
    OP_READ   = 3'd4
  } opcode_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [15:0] seg_increment_in;
    logic [15:0]        seg_ticks_in;
    logic [15:0]        current_rpm;
  } in_word_t;

  typedef struct packed {
    logic               status;
    logic [15:0]        new_rpm;
    logic signed [15:0] seg_increment_out;
    logic [15:0]        seg_ticks_out;
    logic               running;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] inc;
    logic [15:0]        ticks;
  } seg_entry_t;

  // table write request; address travels beside it
  typedef struct packed {
    logic       en_inc;
    logic       en_ticks;
    seg_entry_t entry;
  } tbl_wr_t;

endpackage

// ===== hdl/srg_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module srg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== hdl/srg_table.sv =====
// Segment table: increment and tick stores with write-to-read forwarding.
module srg_table #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  srg_pkg::tbl_wr_t         wr,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output srg_pkg::seg_entry_t      cur,
  output srg_pkg::seg_entry_t      nxt
);
  import srg_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [AW-1:0] rd_addr1;
  logic [15:0]   inc_q0, inc_q1, ticks_q0, ticks_q1;
  logic          hit_inc0, hit_inc1, hit_ticks0, hit_ticks1;
  seg_entry_t    byp;

  assign rd_addr1 = rd_addr + AW'(1);

  srg_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_inc_ram (
    .clk    (clk),
    .we     (wr.en_inc),
    .waddr  (wr_addr),
    .wdata  (wr.entry.inc),
    .raddr0 (rd_addr),
    .raddr1 (rd_addr1),
    .rdata0 (inc_q0),
    .rdata1 (inc_q1)
  );

  srg_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ticks_ram (
    .clk    (clk),
    .we     (wr.en_ticks),
    .waddr  (wr_addr),
    .wdata  (wr.entry.ticks),
    .raddr0 (rd_addr),
    .raddr1 (rd_addr1),
    .rdata0 (ticks_q0),
    .rdata1 (ticks_q1)
  );

  // RAM reads old data on a same-cycle write; forward the new value
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_inc0   <= 1'b0;
      hit_inc1   <= 1'b0;
      hit_ticks0 <= 1'b0;
      hit_ticks1 <= 1'b0;
    end else begin
      hit_inc0   <= wr.en_inc   && (wr_addr == rd_addr);
      hit_inc1   <= wr.en_inc   && (wr_addr == rd_addr1);
      hit_ticks0 <= wr.en_ticks && (wr_addr == rd_addr);
      hit_ticks1 <= wr.en_ticks && (wr_addr == rd_addr1);
    end
    byp <= wr.entry;
  end

  always_comb begin
    cur.inc   = hit_inc0   ? byp.inc   : signed'(inc_q0);
    cur.ticks = hit_ticks0 ? byp.ticks : ticks_q0;
    nxt.inc   = hit_inc1   ? byp.inc   : signed'(inc_q1);
    nxt.ticks = hit_ticks1 ? byp.ticks : ticks_q1;
  end

endmodule

// ===== hdl/srg_step.sv =====
// Per-word opcode logic: next state, table write and result word.
module srg_step #(
  parameter int DEPTH = 16
) (
  input  srg_pkg::in_word_t        word,
  input  logic [$clog2(DEPTH)-1:0] fill_count,
  input  logic [$clog2(DEPTH)-1:0] read_position,
  input  logic                     ramp_on,
  input  srg_pkg::seg_entry_t      cur,
  input  srg_pkg::seg_entry_t      nxt,
  input  logic [15:0]              max_rpm,
  output logic [$clog2(DEPTH)-1:0] fill_count_next,
  output logic [$clog2(DEPTH)-1:0] read_position_next,
  output logic                     ramp_on_next,
  output srg_pkg::tbl_wr_t         wr,
  output logic [$clog2(DEPTH)-1:0] wr_addr,
  output srg_pkg::out_word_t       result
);
  import srg_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW:0]        rp_inc;
  logic               has_cur, has_nxt, adv;
  seg_entry_t         sel;
  logic signed [17:0] sum;
  logic [15:0]        clamped;

  assign rp_inc  = {1'b0, read_position} + (AW+1)'(1);
  assign has_cur = read_position < fill_count;
  assign has_nxt = rp_inc < {1'b0, fill_count};
  assign adv     = (cur.ticks == 16'd0);
  assign sel     = adv ? nxt : cur;
  assign sum     = $signed({2'b00, word.current_rpm})
                 + $signed({{2{sel.inc[15]}}, sel.inc});

  always_comb begin
    if (sum[17]) begin
      clamped = 16'd0;
    end else if (sum[16:0] > {1'b0, max_rpm}) begin
      clamped = max_rpm;
    end else begin
      clamped = sum[15:0];
    end
  end

  always_comb begin
    fill_count_next          = fill_count;
    read_position_next       = read_position;
    ramp_on_next             = ramp_on;
    wr                       = '0;
    wr_addr                  = fill_count;
    result.status            = ST_REJECT;
    result.new_rpm           = word.current_rpm;
    result.seg_increment_out = '0;
    result.seg_ticks_out     = '0;
    case (word.opcode)
      OP_CLEAR: begin
        fill_count_next    = '0;
        read_position_next = '0;
        ramp_on_next       = 1'b0;
        result.status      = ST_OK;
      end
      OP_APPEND: begin
        if (fill_count < LAST && !ramp_on) begin
          wr.en_inc         = 1'b1;
          wr.en_ticks       = 1'b1;
          wr.entry.inc      = word.seg_increment_in;
          wr.entry.ticks    = word.seg_ticks_in;
          fill_count_next   = fill_count + AW'(1);
          result.status     = ST_OK;
        end
      end
      OP_START: begin
        if (!ramp_on && has_cur) begin
          ramp_on_next      = 1'b1;
          result.status     = ST_OK;
        end else begin
          ramp_on_next      = 1'b0;
        end
      end
      OP_TICK: begin
        if (!has_cur || (adv && !has_nxt)) begin
          ramp_on_next = 1'b0;  // end of waveform
        end else begin
          read_position_next = adv ? rp_inc[AW-1:0] : read_position;
          wr_addr            = read_position_next;
          wr.en_ticks        = (sel.ticks != 16'd0);  // count never wraps
          wr.entry.ticks     = sel.ticks - 16'd1;
          result.new_rpm     = clamped;
          result.status      = ST_OK;
        end
      end
      OP_READ: begin
        if (has_cur) begin
          result.seg_increment_out = cur.inc;
          result.seg_ticks_out     = cur.ticks;
          read_position_next       = rp_inc[AW-1:0];
          result.status            = ST_OK;
        end
      end
      default: begin
      end
    endcase
    result.running = ramp_on_next;
  end

endmodule

// ===== hdl/segment_ramp_rpm_generator.sv =====
// Segment ramp rpm generator top level: word registers, state and table.
// A word passes through the input holding register, then its result into the result register.
// Throughput: one word per cycle while the output is not stalled; the table is read ahead through
// registered RAM ports at the read position and the entry after it.
// Reset (rst, synchronous): table empty, read position 0, generator off,
// max_rpm 10000. Table RAM contents are not cleared; the fill count guards them.
module segment_ramp_rpm_generator #(
  parameter int DEPTH = srg_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  srg_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output srg_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import srg_pkg::*;

  localparam int AW = $clog2(DEPTH);

  // input holding register
  logic      hold_valid;
  in_word_t  hold_word;
  // one word is processed when held and the result register can take it
  logic      fire;

  // generator state
  logic [AW-1:0] fill_count, read_position;
  logic          ramp_on;
  logic [15:0]   max_rpm;

  logic [AW-1:0] fill_count_next, read_position_next;
  logic          ramp_on_next;
  tbl_wr_t       step_wr, tbl_wr;
  logic [AW-1:0] wr_addr, rd_addr;
  seg_entry_t    cur, nxt;
  out_word_t     result;

  assign fire      = hold_valid && (!out_valid || !out_stall);
  assign in_stall  = hold_valid && !fire;
  assign cfg_ready = 1'b1;

  // table writes only for a word that is actually processed
  always_comb begin
    tbl_wr          = step_wr;
    tbl_wr.en_inc   = step_wr.en_inc && fire;
    tbl_wr.en_ticks = step_wr.en_ticks && fire;
  end

  // prefetch: read the entries at the position the next word will see
  assign rd_addr = fire ? read_position_next : read_position;

  srg_table #(.DEPTH(DEPTH)) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr      (tbl_wr),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .cur     (cur),
    .nxt     (nxt)
  );

  srg_step #(.DEPTH(DEPTH)) u_step (
    .word               (hold_word),
    .fill_count         (fill_count),
    .read_position      (read_position),
    .ramp_on            (ramp_on),
    .cur                (cur),
    .nxt                (nxt),
    .max_rpm            (max_rpm),
    .fill_count_next    (fill_count_next),
    .read_position_next (read_position_next),
    .ramp_on_next       (ramp_on_next),
    .wr                 (step_wr),
    .wr_addr            (wr_addr),
    .result             (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
    if (!in_stall) begin
      hold_word <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      read_position <= '0;
      ramp_on       <= 1'b0;
    end else if (fire) begin
      fill_count    <= fill_count_next;
      read_position <= read_position_next;
      ramp_on       <= ramp_on_next;
    end
  end

  // max_rpm only changes while idle: the user must keep to this, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      max_rpm <= MAX_RPM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_rpm <= cfg_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (fire) begin
      out_word <= result;
    end
  end

`ifndef SYNTHESIS
  a_rp_le_fill: assert property (@(posedge clk) disable iff (rst)
    read_position <= fill_count)
    else $error("read position past fill count");

  a_fire_out: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed word produced no result");

  a_fill_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(fill_count) && $stable(read_position))
    else $error("table state moved without a word");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    fire && hold_word.opcode == OP_CLEAR |=>
      fill_count == '0 && read_position == '0 && !ramp_on)
    else $error("clear did not empty the table");
`endif

endmodule
